// File: hw/rtl/ror_pkg.sv
// Relay output router package: item kind, mode, level select and status codes,
// plus the structs passed between the lanes, the merge stage and the top level.
// No dependencies.
`default_nettype none

package ror_pkg;

  // Fixed width of the per-channel bit fields on the ports
  localparam int FIELD_BITS = 4;
  localparam int DUR_BITS   = 16;

  // Item kinds
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_FORCE  = 2'd1;
  localparam logic [1:0] KIND_SETM   = 2'd2;

  // Channel modes and mode-set commands
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_ON      = 3'd1;
  localparam logic [2:0] MODE_WDOG    = 3'd2;
  localparam logic [2:0] MODE_SCHED   = 3'd3;
  localparam logic [2:0] MODE_SCHWD   = 3'd4;
  localparam logic [2:0] MODE_LOGIC   = 3'd5;
  localparam logic [2:0] MODE_FLIP    = 3'd6;
  localparam logic [2:0] MODE_INVALID = 3'd7;

  // Forced level select
  localparam logic [1:0] SEL_OFF  = 2'd0;
  localparam logic [1:0] SEL_ON   = 2'd1;
  localparam logic [1:0] SEL_BASE = 2'd2;
  localparam logic [1:0] SEL_BAD  = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Decoded command broadcast to all lanes
  typedef struct packed {
    logic       upd;
    logic       frc;
    logic       setm;
    logic       tick;
    logic [1:0] sel;
    logic [2:0] nm;
  } ror_cmd_t;

  // Per-item info needed by the merge stage
  typedef struct packed {
    logic       acc;
    logic [1:0] kind;
    logic [1:0] sel;
    logic [2:0] nm;
  } ror_item_t;

  // What one lane reports
  typedef struct packed {
    logic level;
    logic flip_bad;
  } ror_lane_t;

  // One result transaction
  typedef struct packed {
    logic [FIELD_BITS-1:0] relay;
    logic [FIELD_BITS-1:0] changed;
    logic [1:0]            status;
  } ror_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/ror_lane.sv
// One relay channel lane: mode, forced level and forced countdown state,
// and the next relay level for an update. Depends on ror_pkg.
`default_nettype none

module ror_lane #(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ror_pkg::ror_cmd_t            cmd_i,
  input  wire logic                         hit_i,
  input  wire logic                         wdog_i,
  input  wire logic                         sched_i,
  input  wire logic                         logic_i,
  input  wire logic                         rst_lvl_i,
  input  wire logic [ror_pkg::DUR_BITS-1:0] duration_i,
  output ror_pkg::ror_lane_t                lane_o
);

  localparam logic [TIMER_BITS-1:0] TMR_MAX = '1;
  localparam logic [TIMER_BITS-1:0] TMR_ONE = {{(TIMER_BITS-1){1'b0}}, 1'b1};

  logic [2:0]            mode_q, mode_d;
  logic [TIMER_BITS-1:0] cd_q, cd_d, cd_dec, cd_load;
  logic                  flvl_q, flvl_d;
  logic                  mode_lvl, base_lvl;
  logic                  manual;

  assign cd_dec = (cmd_i.upd && cmd_i.tick && (cd_q != '0)) ? cd_q - TMR_ONE : cd_q;
  assign manual = (mode_q == ror_pkg::MODE_OFF) || (mode_q == ror_pkg::MODE_ON);

  // saturate the load when the timer is narrower than the duration field
  always_comb begin
    if (32'(duration_i) > 32'(TMR_MAX)) begin
      cd_load = TMR_MAX;
    end else begin
      cd_load = TIMER_BITS'(duration_i);
    end
  end

  always_comb begin
    mode_lvl = 1'b0;
    base_lvl = 1'b0;
    case (mode_q)
      ror_pkg::MODE_OFF: begin
        mode_lvl = 1'b0;
        base_lvl = 1'b0;
      end
      ror_pkg::MODE_ON: begin
        mode_lvl = 1'b1;
        base_lvl = 1'b1;
      end
      ror_pkg::MODE_WDOG: begin
        mode_lvl = wdog_i;
        base_lvl = ~rst_lvl_i;
      end
      ror_pkg::MODE_SCHED: begin
        mode_lvl = sched_i;
        base_lvl = sched_i;
      end
      ror_pkg::MODE_SCHWD: begin
        // watchdog may only pull the schedule toward the reset level
        mode_lvl = ((sched_i != rst_lvl_i) && (wdog_i == rst_lvl_i)) ? rst_lvl_i : sched_i;
        base_lvl = sched_i;
      end
      ror_pkg::MODE_LOGIC: begin
        mode_lvl = logic_i;
        base_lvl = logic_i;
      end
      default: begin
        mode_lvl = 1'b0;
        base_lvl = 1'b0;
      end
    endcase
  end

  assign lane_o.level    = (cd_dec != '0) ? flvl_q : mode_lvl;
  assign lane_o.flip_bad = hit_i && (cmd_i.nm == ror_pkg::MODE_FLIP) && !manual;

  always_comb begin
    mode_d = mode_q;
    cd_d   = cd_q;
    flvl_d = flvl_q;
    if (cmd_i.upd) begin
      cd_d = cd_dec;
    end
    if (cmd_i.frc && hit_i) begin
      flvl_d = (cmd_i.sel == ror_pkg::SEL_BASE) ? ~base_lvl : cmd_i.sel[0];
      cd_d   = cd_load;
    end
    if (cmd_i.setm && hit_i) begin
      if (cmd_i.nm == ror_pkg::MODE_FLIP) begin
        if (manual) begin
          mode_d = mode_q ^ 3'd1;
        end
      end else begin
        mode_d = cmd_i.nm;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ror_pkg::MODE_ON;
      cd_q   <= '0;
      flvl_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      cd_q   <= cd_d;
      flvl_q <= flvl_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ror_merge.sv
// Merge stage: gathers the lane levels into the relay word, forms status and
// the changed mask, and holds the result in an output register with a skid entry.
// Depends on ror_pkg.
`default_nettype none

module ror_merge #(
  parameter int CHANNELS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ror_pkg::ror_item_t   item_i,
  input  wire logic [CHANNELS-1:0]  level_i,
  input  wire logic [CHANNELS-1:0]  flip_bad_i,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output ror_pkg::ror_res_t         res_o,
  output logic                      busy_o
);

  logic [CHANNELS-1:0] relay_q, relay_d, chg;
  logic                upd;
  logic [1:0]          status;
  ror_pkg::ror_res_t   res, main_q, skid_q;
  logic                main_v_q, skid_v_q;
  logic                take;

  assign upd     = item_i.acc && (item_i.kind == ror_pkg::KIND_UPDATE);
  assign relay_d = upd ? level_i : relay_q;
  assign chg     = upd ? (level_i ^ relay_q) : '0;

  always_comb begin
    case (item_i.kind)
      ror_pkg::KIND_UPDATE: status = ror_pkg::ST_OK;
      ror_pkg::KIND_FORCE:
        status = (item_i.sel == ror_pkg::SEL_BAD) ? ror_pkg::ST_INVALID : ror_pkg::ST_OK;
      ror_pkg::KIND_SETM: begin
        if (item_i.nm == ror_pkg::MODE_INVALID) begin
          status = ror_pkg::ST_INVALID;
        end else if (|flip_bad_i) begin
          status = ror_pkg::ST_IGNORED;
        end else begin
          status = ror_pkg::ST_OK;
        end
      end
      default: status = ror_pkg::ST_INVALID;
    endcase
  end

  for (genvar i = 0; i < ror_pkg::FIELD_BITS; i++) begin : g_bits
    if (i < CHANNELS) begin : g_used
      assign res.relay[i]   = relay_d[i];
      assign res.changed[i] = chg[i];
    end else begin : g_pad
      assign res.relay[i]   = 1'b0;
      assign res.changed[i] = 1'b0;
    end
  end
  assign res.status = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q <= '0;
    end else begin
      relay_q <= relay_d;
    end
  end

  assign take        = main_v_q && !out_stall_i;
  assign out_valid_o = main_v_q;
  assign res_o       = main_q;
  assign busy_o      = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (item_i.acc) begin
      if (!main_v_q || take) begin
        main_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        main_q <= skid_q;
      end
    end else if (item_i.acc) begin
      if (!main_v_q || take) begin
        main_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

`ifndef SYNTH
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry holds a transaction while the output register is empty");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !item_i.acc)
    else $error("transaction accepted while the skid entry is occupied");

  a_relay_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.acc && (item_i.kind != ror_pkg::KIND_UPDATE)) |=> $stable(relay_q))
    else $error("relay levels moved on a non-update transaction");

  a_accept_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.acc |=> main_v_q)
    else $error("accepted transaction produced no pending result");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/relay_output_router_top.sv
// Relay output router, top level: decodes the item, runs one lane per channel
// and merges the lane results. Depends on ror_pkg, ror_lane and ror_merge.
`default_nettype none

// Routes CHANNELS relay outputs from manual, watchdog, schedule, schedule plus
// watchdog or logic sources, with a per-channel forced level held by a tick
// countdown. One transaction is accepted every clock while in_stall_o is low; every
// channel lane updates its state in the accepting cycle. A two-entry output buffer
// (register plus skid entry) lets one more transaction in while a result is
// stalled; in_stall_o rises only when the skid entry is occupied. Field ports are
// four channels wide; channels at index four and above are not addressable and
// read their source bits as zero. The user writes wdog_reset_level through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce it.
module relay_output_router_top #(
  parameter int CHANNELS   = 4,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ror_pkg::FIELD_BITS-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     mode_i,
  input  wire logic                           tick_i,
  input  wire logic [ror_pkg::FIELD_BITS-1:0] wdog_bits_i,
  input  wire logic [ror_pkg::FIELD_BITS-1:0] sched_bits_i,
  input  wire logic [ror_pkg::FIELD_BITS-1:0] logic_bits_i,
  input  wire logic [1:0]                     channel_i,
  input  wire logic [ror_pkg::DUR_BITS-1:0]   duration_i,
  input  wire logic [1:0]                     level_select_i,
  input  wire logic [2:0]                     new_mode_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [ror_pkg::FIELD_BITS-1:0]      relay_bits_o,
  output logic [ror_pkg::FIELD_BITS-1:0]      changed_bits_o,
  output logic [1:0]                          status_o
);

  logic [ror_pkg::FIELD_BITS-1:0] rst_lvl_q;
  logic                           acc, busy;
  ror_pkg::ror_cmd_t              cmd;
  ror_pkg::ror_item_t             item;
  ror_pkg::ror_res_t              res;
  logic [CHANNELS-1:0]            level, flip_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_lvl_q <= '0;
    end else if (cfg_we_i) begin
      rst_lvl_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = busy;
  assign acc        = in_valid_i && !busy;

  assign cmd.upd  = acc && (mode_i == ror_pkg::KIND_UPDATE);
  assign cmd.frc  = acc && (mode_i == ror_pkg::KIND_FORCE) && (level_select_i != ror_pkg::SEL_BAD);
  assign cmd.setm = acc && (mode_i == ror_pkg::KIND_SETM) && (new_mode_i != ror_pkg::MODE_INVALID);
  assign cmd.tick = tick_i;
  assign cmd.sel  = level_select_i;
  assign cmd.nm   = new_mode_i;

  assign item.acc  = acc;
  assign item.kind = mode_i;
  assign item.sel  = level_select_i;
  assign item.nm   = new_mode_i;

  for (genvar n = 0; n < CHANNELS; n++) begin : g_lane
    logic               wb, sb, lb, rl, hit;
    ror_pkg::ror_lane_t lane;

    if (n < ror_pkg::FIELD_BITS) begin : g_src
      assign wb = wdog_bits_i[n];
      assign sb = sched_bits_i[n];
      assign lb = logic_bits_i[n];
      assign rl = rst_lvl_q[n];
    end else begin : g_nosrc
      assign wb = 1'b0;
      assign sb = 1'b0;
      assign lb = 1'b0;
      assign rl = 1'b0;
    end
    assign hit = (32'(channel_i) == n);

    ror_lane #(
      .TIMER_BITS(TIMER_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .hit_i      (hit),
      .wdog_i     (wb),
      .sched_i    (sb),
      .logic_i    (lb),
      .rst_lvl_i  (rl),
      .duration_i (duration_i),
      .lane_o     (lane)
    );

    assign level[n]    = lane.level;
    assign flip_bad[n] = lane.flip_bad;
  end

  ror_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .level_i     (level),
    .flip_bad_i  (flip_bad),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .busy_o      (busy)
  );

  assign relay_bits_o   = res.relay;
  assign changed_bits_o = res.changed;
  assign status_o       = res.status;

endmodule

`default_nettype wire

// File: tb/tb_relay_output_router_top.sv
// Testbench for relay_output_router_top: directed and random transactions,
// checked against a built-in predictor of the relay levels, changed mask and status.
// Depends on ror_pkg and the relay_output_router_top RTL.
module tb_relay_output_router_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 4;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]                     kind;
    logic                           tick;
    logic [ror_pkg::FIELD_BITS-1:0] wdog;
    logic [ror_pkg::FIELD_BITS-1:0] sched;
    logic [ror_pkg::FIELD_BITS-1:0] lgc;
    logic [1:0]                     chan;
    logic [ror_pkg::DUR_BITS-1:0]   dur;
    logic [1:0]                     sel;
    logic [2:0]                     nm;
  } relay_item_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [ror_pkg::FIELD_BITS-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [1:0]                     mode_i = '0;
  logic                           tick_i = 1'b0;
  logic [ror_pkg::FIELD_BITS-1:0] wdog_bits_i = '0;
  logic [ror_pkg::FIELD_BITS-1:0] sched_bits_i = '0;
  logic [ror_pkg::FIELD_BITS-1:0] logic_bits_i = '0;
  logic [1:0]                     channel_i = '0;
  logic [ror_pkg::DUR_BITS-1:0]   duration_i = '0;
  logic [1:0]                     level_select_i = '0;
  logic [2:0]                     new_mode_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [ror_pkg::FIELD_BITS-1:0] relay_bits_o;
  logic [ror_pkg::FIELD_BITS-1:0] changed_bits_o;
  logic [1:0]                     status_o;

  // predicted block state
  logic [ror_pkg::FIELD_BITS-1:0] wd_level_cfg;
  logic [2:0]                     chan_mode [NCH];
  logic [ror_pkg::DUR_BITS-1:0]   force_cnt [NCH];
  logic                           force_lvl [NCH];
  logic [ror_pkg::FIELD_BITS-1:0] pred_relay;

  ror_pkg::ror_res_t pending_results [$];
  int                mismatch_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  relay_output_router_top #(
    .CHANNELS   (NCH),
    .TIMER_BITS (ror_pkg::DUR_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .tick_i         (tick_i),
    .wdog_bits_i    (wdog_bits_i),
    .sched_bits_i   (sched_bits_i),
    .logic_bits_i   (logic_bits_i),
    .channel_i      (channel_i),
    .duration_i     (duration_i),
    .level_select_i (level_select_i),
    .new_mode_i     (new_mode_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .relay_bits_o   (relay_bits_o),
    .changed_bits_o (changed_bits_o),
    .status_o       (status_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Level a channel's mode selects; without the watchdog it is the base state.
  function automatic logic source_level(int n, logic use_wd,
                                        logic [ror_pkg::FIELD_BITS-1:0] wb,
                                        logic [ror_pkg::FIELD_BITS-1:0] sb,
                                        logic [ror_pkg::FIELD_BITS-1:0] lb);
    logic rl;
    logic lvl;
    rl = wd_level_cfg[n];
    case (chan_mode[n])
      ror_pkg::MODE_OFF:   lvl = 1'b0;
      ror_pkg::MODE_ON:    lvl = 1'b1;
      ror_pkg::MODE_WDOG:  lvl = use_wd ? wb[n] : ~rl;
      ror_pkg::MODE_SCHED: lvl = sb[n];
      ror_pkg::MODE_SCHWD: begin
        lvl = sb[n];
        // watchdog may only pull the schedule toward the reset level
        if (use_wd && lvl != rl && wb[n] == rl) lvl = rl;
      end
      ror_pkg::MODE_LOGIC: lvl = lb[n];
      default:             lvl = 1'b0;
    endcase
    return lvl;
  endfunction

  function automatic ror_pkg::ror_res_t apply_item(relay_item_t it);
    ror_pkg::ror_res_t              r;
    logic [ror_pkg::FIELD_BITS-1:0] nxt;
    r = '0;
    nxt = '0;
    case (it.kind)
      ror_pkg::KIND_UPDATE: begin
        for (int n = 0; n < NCH; n++) begin
          if (it.tick && force_cnt[n] != 0) force_cnt[n]--;
          nxt[n] = source_level(n, 1'b1, it.wdog, it.sched, it.lgc);
          if (force_cnt[n] != 0) nxt[n] = force_lvl[n];
        end
        r.changed = nxt ^ pred_relay;
        pred_relay = nxt;
      end
      ror_pkg::KIND_FORCE: begin
        if (it.sel == ror_pkg::SEL_BAD) begin
          r.status = ror_pkg::ST_INVALID;
        end else begin
          force_lvl[it.chan] = (it.sel == ror_pkg::SEL_BASE) ?
              ~source_level(int'(it.chan), 1'b0, it.wdog, it.sched, it.lgc) : it.sel[0];
          force_cnt[it.chan] = it.dur;
        end
      end
      ror_pkg::KIND_SETM: begin
        if (it.nm == ror_pkg::MODE_INVALID) begin
          r.status = ror_pkg::ST_INVALID;
        end else if (it.nm == ror_pkg::MODE_FLIP) begin
          if (chan_mode[it.chan] == ror_pkg::MODE_OFF) chan_mode[it.chan] = ror_pkg::MODE_ON;
          else if (chan_mode[it.chan] == ror_pkg::MODE_ON) chan_mode[it.chan] = ror_pkg::MODE_OFF;
          else r.status = ror_pkg::ST_IGNORED;
        end else begin
          chan_mode[it.chan] = it.nm;
        end
      end
      default: r.status = ror_pkg::ST_INVALID;
    endcase
    r.relay = pred_relay;
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    ror_pkg::ror_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result relay=%h changed=%h status=%0d",
                                  relay_bits_o, changed_bits_o, status_o));
      end else begin
        want = pending_results.pop_front();
        if (relay_bits_o !== want.relay)
          report_mismatch($sformatf("relay_bits %h, want %h", relay_bits_o, want.relay));
        if (changed_bits_o !== want.changed)
          report_mismatch($sformatf("changed_bits %h, want %h", changed_bits_o,
                                    want.changed));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
      end
    end
  end

  function automatic relay_item_t rand_item();
    relay_item_t it;
    int          pick;
    it.tick  = 1'($urandom_range(1));
    it.wdog  = 4'($urandom_range(15));
    it.sched = 4'($urandom_range(15));
    it.lgc   = 4'($urandom_range(15));
    it.chan  = 2'($urandom_range(NCH - 1));
    // short holds dominate so forced channels expire and sources show through
    pick = $urandom_range(99);
    if (pick < 80) it.dur = 16'($urandom_range(6));
    else if (pick < 95) it.dur = 16'($urandom_range(16'hFFFF));
    else it.dur = 16'hFFFF;
    it.sel = ($urandom_range(9) == 0) ? ror_pkg::SEL_BAD : 2'($urandom_range(2));
    it.nm  = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 50) it.kind = ror_pkg::KIND_UPDATE;
    else if (pick < 68) it.kind = ror_pkg::KIND_FORCE;
    else if (pick < 97) it.kind = ror_pkg::KIND_SETM;
    else it.kind = KIND_BAD;
    return it;
  endfunction

  task automatic send_item(relay_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= it.kind;
    tick_i         <= it.tick;
    wdog_bits_i    <= it.wdog;
    sched_bits_i   <= it.sched;
    logic_bits_i   <= it.lgc;
    channel_i      <= it.chan;
    duration_i     <= it.dur;
    level_select_i <= it.sel;
    new_mode_i     <= it.nm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_item(it));
  endtask

  task automatic do_update(logic tick, logic [3:0] wb, logic [3:0] sb, logic [3:0] lb);
    relay_item_t it;
    it = rand_item();
    it.kind = ror_pkg::KIND_UPDATE;
    it.tick = tick;
    it.wdog = wb;
    it.sched = sb;
    it.lgc = lb;
    send_item(it);
  endtask

  task automatic do_force(int ch, logic [1:0] sel, logic [ror_pkg::DUR_BITS-1:0] dur);
    relay_item_t it;
    it = rand_item();
    it.kind = ror_pkg::KIND_FORCE;
    it.chan = 2'(ch);
    it.sel = sel;
    it.dur = dur;
    send_item(it);
  endtask

  task automatic do_setm(int ch, logic [2:0] nm);
    relay_item_t it;
    it = rand_item();
    it.kind = ror_pkg::KIND_SETM;
    it.chan = 2'(ch);
    it.nm = nm;
    send_item(it);
  endtask

  // register writes only with nothing in flight
  task automatic write_reset_level(logic [ror_pkg::FIELD_BITS-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    wd_level_cfg = value;
  endtask

  task automatic test_mode_sources();
    write_reset_level(4'b0101);
    do_update(1'b0, 4'h0, 4'h0, 4'h0);
    do_setm(0, ror_pkg::MODE_OFF);
    do_setm(1, ror_pkg::MODE_WDOG);
    do_setm(2, ror_pkg::MODE_SCHED);
    do_setm(3, ror_pkg::MODE_SCHWD);
    do_update(1'b0, 4'hF, 4'h0, 4'hF);
    do_update(1'b1, 4'h0, 4'hF, 4'h0);
    do_setm(0, ror_pkg::MODE_LOGIC);
    do_setm(1, ror_pkg::MODE_INVALID);
    do_setm(2, ror_pkg::MODE_FLIP);
    do_update(1'b0, 4'b1010, 4'b0101, 4'hF);
  endtask

  task automatic test_manual_flip();
    relay_item_t it;
    do_setm(0, ror_pkg::MODE_ON);
    do_setm(0, ror_pkg::MODE_FLIP);
    do_setm(0, ror_pkg::MODE_FLIP);
    it = rand_item();
    it.kind = KIND_BAD;
    send_item(it);
  endtask

  task automatic test_forced_levels();
    do_force(1, ror_pkg::SEL_ON, 16'd2);
    do_force(2, ror_pkg::SEL_BASE, 16'hFFFF);
    do_force(3, ror_pkg::SEL_OFF, 16'd1);
    do_force(0, ror_pkg::SEL_BAD, 16'd5);
    do_update(1'b0, 4'h0, 4'hF, 4'h0);
    do_update(1'b1, 4'hF, 4'h0, 4'hF);
    do_update(1'b1, 4'h0, 4'hF, 4'h0);
    do_force(2, ror_pkg::SEL_OFF, 16'd0);
    do_update(1'b1, 4'hF, 4'hF, 4'hF);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct,
                                     logic [ror_pkg::FIELD_BITS-1:0] level);
    write_reset_level(level);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(rand_item());
  endtask

  initial begin
    wd_level_cfg = '0;
    pred_relay   = '0;
    for (int n = 0; n < NCH; n++) begin
      chan_mode[n] = ror_pkg::MODE_ON;
      force_cnt[n] = '0;
      force_lvl[n] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 10;
    recv_stall_pct = 53;
    test_mode_sources();
    test_manual_flip();
    test_forced_levels();
    test_random_traffic(300, 10, 53, 4'hF);
    test_random_traffic(300, 53, 10, 4'($urandom_range(15)));
    test_random_traffic(300, 0, 0, 4'h0);

    in_valid_i <= 1'b0;
    for (int c = 0; c < 2000 && pending_results.size() != 0; c++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
